[hw/rtl/tlqf_pkg.sv]
// Shared types, codes and the microprogram of the transverse leakage fit block.
package tlqf_pkg;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SAT,
    OP_END
  } op_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_DFIN,
    AS_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_FETCH,
    EX_ISSUE,
    EX_WAIT
  } ex_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_LEAK_GO,
    T_LEAK_WAIT,
    T_FIRST,
    T_EMIT_GO,
    T_EMIT_WAIT,
    T_OUT,
    T_UPDATE,
    T_END
  } top_state_t;

  // Operand and destination selectors: codes below 16 address the scratch file.
  localparam int RF_BITS = 4;
  typedef logic [RF_BITS:0] sel_t;

  localparam sel_t R0  = 5'd0;
  localparam sel_t R1  = 5'd1;
  localparam sel_t R2  = 5'd2;
  localparam sel_t R3  = 5'd3;
  localparam sel_t R4  = 5'd4;
  localparam sel_t R5  = 5'd5;
  localparam sel_t R6  = 5'd6;
  localparam sel_t R7  = 5'd7;
  localparam sel_t R8  = 5'd8;
  localparam sel_t R9  = 5'd9;
  localparam sel_t R10 = 5'd10;
  localparam sel_t R11 = 5'd11;

  localparam sel_t S_LL    = 5'd16;
  localparam sel_t S_DL    = 5'd17;
  localparam sel_t S_LM    = 5'd18;
  localparam sel_t S_DM    = 5'd19;
  localparam sel_t S_LR    = 5'd20;
  localparam sel_t S_DR    = 5'd21;
  localparam sel_t S_CAL   = 5'd22;
  localparam sel_t S_CAH   = 5'd23;
  localparam sel_t S_CBL   = 5'd24;
  localparam sel_t S_CBH   = 5'd25;
  localparam sel_t S_WSA   = 5'd26;
  localparam sel_t S_WSB   = 5'd27;
  localparam sel_t S_KFRAC = 5'd28;

  localparam sel_t D_LEAK = 5'd16;
  localparam sel_t D_C1   = 5'd17;
  localparam sel_t D_C2   = 5'd18;

  localparam int FRAC_BITS = 16;

  localparam logic [7:0] REG_LEFT_MODE  = 8'd0;
  localparam logic [7:0] REG_RIGHT_MODE = 8'd1;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t a;
    sel_t b;
  } instr_t;

  localparam int PROG_LEN = 36;
  localparam int PC_BITS  = $clog2(PROG_LEN);
  localparam logic [PC_BITS-1:0] PC_LEAK = 6'd0;
  localparam logic [PC_BITS-1:0] PC_EMIT = 6'd9;

  localparam instr_t PROG [PROG_LEN] = '{
    // Average transverse leakage of the new node.
    '{OP_SUB, R0, S_CAH, S_CAL},
    '{OP_MUL, R0, R0, S_KFRAC},
    '{OP_DIV, R1, R0, S_WSA},
    '{OP_SUB, R2, S_CBH, S_CBL},
    '{OP_MUL, R2, R2, S_KFRAC},
    '{OP_DIV, R3, R2, S_WSB},
    '{OP_ADD, R1, R1, R3},
    '{OP_SAT, D_LEAK, R1, R1},
    '{OP_END, R0, R0, R0},
    // Three-node fit of the middle node.
    '{OP_ADD, R0, S_DM, S_DL},
    '{OP_ADD, R1, S_DM, S_DR},
    '{OP_ADD, R2, R0, S_DR},
    '{OP_MUL, R3, R0, R1},
    '{OP_MUL, R4, R3, R2},
    '{OP_ADD, R4, R4, R4},
    '{OP_ADD, R5, S_DR, S_DR},
    '{OP_ADD, R5, S_DM, R5},
    '{OP_MUL, R5, R1, R5},
    '{OP_ADD, R6, S_DL, S_DL},
    '{OP_ADD, R6, S_DM, R6},
    '{OP_MUL, R6, R0, R6},
    '{OP_SUB, R7, S_LM, S_LL},
    '{OP_SUB, R8, S_LR, S_LM},
    '{OP_SUB, R9, S_LL, S_LM},
    '{OP_MUL, R5, R5, R7},
    '{OP_MUL, R6, R6, R8},
    '{OP_ADD, R5, R5, R6},
    '{OP_MUL, R5, S_DM, R5},
    '{OP_MUL, R10, R0, R8},
    '{OP_MUL, R11, R1, R9},
    '{OP_ADD, R10, R10, R11},
    '{OP_MUL, R11, S_DM, S_DM},
    '{OP_MUL, R10, R11, R10},
    '{OP_DIV, D_C1, R5, R4},
    '{OP_DIV, D_C2, R10, R4},
    '{OP_END, R0, R0, R0}
  };

endpackage

[hw/rtl/transverse_leakage_quadratic_fit.sv]
// Top level of the transverse leakage quadratic fit block.
//
// Nodes of one mesh line arrive on the s_ stream, one item per node; s_tlast
// marks the node that closes its line and s_tuser the node that opens one.
// Each item first gets its average transverse leakage, then the middle node of
// the three-node window gets its fit; a closing node also flushes its own fit.
// Results leave on the m_ stream, m_tlast set on the final result of an item.
// Boundary modes are written on the cfg_ port (index 0 left, 1 right, bit 0).
// All arithmetic runs on one shared unit under a microprogram, one operation at a
// time: multiply and divide work serially over the BW-bit datapath (BW =
// 3*WIDTH_BITS + VALUE_BITS + 6, 110 by default). The block takes no new item
// until the leakage and any fits of the last one are done.
// s_tready is high only while the block is idle. A result is held in the
// output register until m_tready takes it; the block waits meanwhile.
// Synchronous reset clears the window, the boundary modes and all handshakes.
module transverse_leakage_quadratic_fit import tlqf_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // width_along, width_side_a, width_side_b, current_a_low, current_a_high,
  // current_b_low, current_b_high, zero fill
  input  logic [((3*WIDTH_BITS+4*VALUE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,  // line_end
  input  logic [0:0] s_tuser,  // line_start
  output logic m_tvalid,
  input  logic m_tready,
  // average_leak, linear_coeff, quadratic_coeff, zero fill
  output logic [((3*VALUE_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tlast,  // last_in_run
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int V = VALUE_BITS;
  localparam int W = WIDTH_BITS;
  localparam int OUT_W = ((3 * V + 7) / 8) * 8;

  top_state_t       state, state_next;
  logic             left_mode, right_mode;
  logic signed [V-1:0] left_leak, mid_leak;
  logic [W-1:0]     left_width, mid_width;
  logic             mid_pending;
  logic [W-1:0]     in_w, in_wsa, in_wsb;
  logic signed [V-1:0] in_cal, in_cah, in_cbl, in_cbh;
  logic             in_start, in_end;
  logic signed [V-1:0] ll, lm, lr;
  logic [W-1:0]     dl, dm, dr;
  logic             phase, cont;
  logic [V-1:0]     out_leak, out_c1, out_c2;
  logic             out_last;
  logic             exec_start, exec_done;
  logic [PC_BITS-1:0] exec_entry;
  logic [V-1:0]     leak_val, c1, c2;

  // The new node continues the waiting node's line.
  assign cont      = !in_start && mid_pending;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = state == T_OUT;
  assign m_tdata   = OUT_W'({out_c2, out_c1, out_leak});
  assign m_tlast   = out_last;

  tlqf_exec #(.V(V), .W(W)) u_exec (
    .clk      (clk),
    .rst      (rst),
    .start    (exec_start),
    .entry    (exec_entry),
    .ll       (ll),
    .lm       (lm),
    .lr       (lr),
    .dl       (dl),
    .dm       (dm),
    .dr       (dr),
    .cal      (in_cal),
    .cah      (in_cah),
    .cbl      (in_cbl),
    .cbh      (in_cbh),
    .wsa      (in_wsa),
    .wsb      (in_wsb),
    .done     (exec_done),
    .leak_val (leak_val),
    .c1       (c1),
    .c2       (c2)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    exec_start = 1'b0;
    exec_entry = PC_EMIT;
    case (state)
      T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = T_LEAK_GO;
      end
      T_LEAK_GO: begin
        exec_start = 1'b1;
        exec_entry = PC_LEAK;
        state_next = T_LEAK_WAIT;
      end
      T_LEAK_WAIT: if (exec_done) state_next = T_FIRST;
      T_FIRST:     state_next = mid_pending ? T_EMIT_GO : T_UPDATE;
      T_EMIT_GO: begin
        exec_start = 1'b1;
        state_next = T_EMIT_WAIT;
      end
      T_EMIT_WAIT: if (exec_done) state_next = T_OUT;
      T_OUT:       if (m_tready) state_next = phase ? T_IDLE : T_UPDATE;
      T_UPDATE:    state_next = in_end ? T_END : T_IDLE;
      T_END:       state_next = T_EMIT_GO;
      default:     state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mode   <= 1'b0;
      right_mode  <= 1'b0;
      left_leak   <= '0;
      left_width  <= '0;
      mid_leak    <= '0;
      mid_width   <= '0;
      mid_pending <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEFT_MODE:  left_mode <= cfg_data[0];
          REG_RIGHT_MODE: right_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == T_UPDATE) begin
        if (cont) begin
          left_leak  <= mid_leak;
          left_width <= mid_width;
        end else begin
          left_leak  <= left_mode ? '0 : $signed(leak_val);
          left_width <= left_mode ? '0 : in_w;
        end
        mid_leak    <= $signed(leak_val);
        mid_width   <= in_w;
        mid_pending <= !in_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_IDLE && s_tvalid) begin
      in_w     <= s_tdata[W-1:0];
      in_wsa   <= s_tdata[2*W-1:W];
      in_wsb   <= s_tdata[3*W-1:2*W];
      in_cal   <= s_tdata[3*W+V-1:3*W];
      in_cah   <= s_tdata[3*W+2*V-1:3*W+V];
      in_cbl   <= s_tdata[3*W+3*V-1:3*W+2*V];
      in_cbh   <= s_tdata[3*W+4*V-1:3*W+3*V];
      in_start <= s_tuser[0];
      in_end   <= s_tlast;
    end
    if (state == T_FIRST || state == T_END) begin
      ll    <= left_leak;
      dl    <= left_width;
      lm    <= mid_leak;
      dm    <= mid_width;
      phase <= state == T_END;
      if (state == T_FIRST && cont) begin
        lr <= $signed(leak_val);
        dr <= in_w;
      end else begin
        lr <= right_mode ? '0 : mid_leak;
        dr <= right_mode ? '0 : mid_width;
      end
    end
    if (state == T_EMIT_WAIT && exec_done) begin
      out_leak <= lm;
      out_c1   <= c1;
      out_c2   <= c2;
      out_last <= phase || !in_end;
    end
  end

endmodule

[hw/rtl/tlqf_alu.sv]
// Shared arithmetic unit: add, subtract, saturate, serial multiply, restoring divide.
module tlqf_alu import tlqf_pkg::*; #(
  parameter int BW = 110,
  parameter int V  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  op_t           op,
  input  logic [BW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [BW-1:0] y
);

  localparam int CW = $clog2(BW + 1);
  localparam logic [BW-1:0] VMAX     = (BW'(1) << (V - 1)) - BW'(1);
  localparam logic [BW-1:0] VMIN     = ~VMAX;
  localparam logic [BW-1:0] VMIN_MAG = VMAX + BW'(1);

  alu_state_t    state, state_next;
  logic [CW-1:0] cnt;
  logic [BW-1:0] acc, mc, mp, y_r;
  logic          neg;
  logic [BW-1:0] a_mag, rem_sh, rem_dif, acc_sum;
  logic          rem_ge;

  assign a_mag   = a[BW-1] ? -a : a;
  assign rem_sh  = {acc[BW-2:0], mp[BW-1]};
  assign rem_dif = rem_sh - mc;
  assign rem_ge  = rem_sh >= mc;
  assign acc_sum = mp[0] ? acc + mc : acc;
  assign done    = state == AS_DONE;
  assign y       = y_r;

  function automatic logic [BW-1:0] sat_val(input logic [BW-1:0] x);
    logic [BW-1:0] r;
    if ($signed(x) > $signed(VMAX)) r = VMAX;
    else if ($signed(x) < $signed(VMIN)) r = VMIN;
    else r = x;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) state <= AS_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      AS_IDLE: begin
        if (start) begin
          case (op)
            OP_MUL:  state_next = AS_MUL;
            OP_DIV:  state_next = (b == '0) ? AS_DONE : AS_DIV;
            default: state_next = AS_DONE;
          endcase
        end
      end
      AS_MUL:  if (cnt == CW'(1)) state_next = AS_DONE;
      AS_DIV:  if (cnt == CW'(1)) state_next = AS_DFIN;
      AS_DFIN: state_next = AS_DONE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (start) begin
          cnt <= CW'(BW);
          case (op)
            OP_ADD: y_r <= a + b;
            OP_SUB: y_r <= a - b;
            OP_SAT: y_r <= sat_val(a);
            OP_MUL: begin
              acc <= '0;
              mc  <= a;
              mp  <= b;
            end
            OP_DIV: begin
              acc <= '0;
              mc  <= b;
              mp  <= a_mag;
              neg <= a[BW-1];
              // Result for a zero divisor; overwritten when the divide runs.
              y_r <= (a == '0) ? '0 : (a[BW-1] ? VMIN : VMAX);
            end
            default: y_r <= '0;
          endcase
        end
      end
      AS_MUL: begin
        acc <= acc_sum;
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) y_r <= acc_sum;
      end
      AS_DIV: begin
        acc <= rem_ge ? rem_dif : rem_sh;
        mp  <= {mp[BW-2:0], rem_ge};
        cnt <= cnt - CW'(1);
      end
      AS_DFIN: begin
        if (neg) y_r <= (mp > VMIN_MAG) ? VMIN : -mp;
        else y_r <= (mp > VMAX) ? VMAX : mp;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/tlqf_exec.sv]
// Microprogram sequencer with scratch register file around the shared arithmetic unit.
module tlqf_exec import tlqf_pkg::*; #(
  parameter int V = 32,
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PC_BITS-1:0]  entry,
  input  logic signed [V-1:0] ll,
  input  logic signed [V-1:0] lm,
  input  logic signed [V-1:0] lr,
  input  logic [W-1:0]        dl,
  input  logic [W-1:0]        dm,
  input  logic [W-1:0]        dr,
  input  logic signed [V-1:0] cal,
  input  logic signed [V-1:0] cah,
  input  logic signed [V-1:0] cbl,
  input  logic signed [V-1:0] cbh,
  input  logic [W-1:0]        wsa,
  input  logic [W-1:0]        wsb,
  output logic                done,
  output logic [V-1:0]        leak_val,
  output logic [V-1:0]        c1,
  output logic [V-1:0]        c2
);

  localparam int BW = 3 * W + V + 6;

  ex_state_t          state, state_next;
  logic [PC_BITS-1:0] pc;
  instr_t             ins, ins_nxt;
  logic [BW-1:0]      rf [2**RF_BITS];
  logic [BW-1:0]      rd_a, rd_b, opa, opb, alu_y;
  logic               alu_start, alu_done, last, wr_en;

  assign ins     = PROG[pc];
  assign ins_nxt = PROG[pc + PC_BITS'(1)];
  assign last    = ins_nxt.op == OP_END;
  assign wr_en   = (state == EX_WAIT) && alu_done && !ins.dst[RF_BITS];

  function automatic logic [BW-1:0] operand(input sel_t s, input logic [BW-1:0] rd);
    logic [BW-1:0] v;
    case (s)
      S_LL:    v = BW'(ll);
      S_LM:    v = BW'(lm);
      S_LR:    v = BW'(lr);
      S_DL:    v = BW'(dl);
      S_DM:    v = BW'(dm);
      S_DR:    v = BW'(dr);
      S_CAL:   v = BW'(cal);
      S_CAH:   v = BW'(cah);
      S_CBL:   v = BW'(cbl);
      S_CBH:   v = BW'(cbh);
      S_WSA:   v = BW'(wsa);
      S_WSB:   v = BW'(wsb);
      S_KFRAC: v = BW'(1) << FRAC_BITS;
      default: v = rd;
    endcase
    return v;
  endfunction

  assign opa = operand(ins.a, rd_a);
  assign opb = operand(ins.b, rd_b);

  tlqf_alu #(.BW(BW), .V(V)) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (ins.op),
    .a     (opa),
    .b     (opb),
    .done  (alu_done),
    .y     (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= EX_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    alu_start  = 1'b0;
    case (state)
      EX_IDLE:  if (start) state_next = EX_FETCH;
      EX_FETCH: state_next = EX_ISSUE;
      EX_ISSUE: begin
        alu_start  = 1'b1;
        state_next = EX_WAIT;
      end
      EX_WAIT:  if (alu_done) state_next = last ? EX_IDLE : EX_FETCH;
      default:  state_next = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == EX_WAIT) && alu_done && last;
      if (state == EX_IDLE && start) pc <= entry;
      else if (state == EX_WAIT && alu_done && !last) pc <= pc + PC_BITS'(1);
    end
  end

  // Scratch file: two registered reads, one write.
  always_ff @(posedge clk) begin
    if (state == EX_FETCH) begin
      rd_a <= rf[ins.a[RF_BITS-1:0]];
      rd_b <= rf[ins.b[RF_BITS-1:0]];
    end
    if (wr_en) rf[ins.dst[RF_BITS-1:0]] <= alu_y;
  end

  always_ff @(posedge clk) begin
    if (state == EX_WAIT && alu_done) begin
      case (ins.dst)
        D_LEAK:  leak_val <= alu_y[V-1:0];
        D_C1:    c1 <= alu_y[V-1:0];
        D_C2:    c2 <= alu_y[V-1:0];
        default: ;
      endcase
    end
  end

endmodule
